FILE: hdl/segment_box_intersect_defines.svh
// Assertion macros for the segment/box intersection checker.
`ifndef SEGMENT_BOX_INTERSECT_DEFINES_SVH
`define SEGMENT_BOX_INTERSECT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SBI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SBI_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/sbi_pkg.sv
// Shared types and constants for the segment/box intersection block.
`default_nettype none
package sbi_pkg;

	localparam int unsigned NUM_AXES  = 3;
	localparam int unsigned NUM_PAIRS = 6;

	typedef logic [1:0] axis_t;

	// Per-axis slab status handed from a lane to the merge stage.
	typedef struct packed {
		logic par;     // segment parallel to this axis
		logic par_ok;  // start lies within [low, low + extent]
	} slab_flags_t;

	// Ordered pairs of distinct axes (i, j) for the cross-slab checks.
	localparam axis_t PAIR_I [NUM_PAIRS] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
	localparam axis_t PAIR_J [NUM_PAIRS] = '{2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1};

endpackage
`default_nettype wire

FILE: hdl/sbi_lane.sv
// One axis lane: slab bounds as exact fractions num/den, with den > 0 unless the segment is parallel.
`default_nettype none
module sbi_lane #(
	parameter int unsigned W = 32
) (
	input  wire logic                  clk,
	input  wire logic                  en,
	input  wire logic signed [W-1:0]   start,
	input  wire logic signed [W-1:0]   stop,
	input  wire logic signed [W-1:0]   low,
	input  wire logic        [W-2:0]   extent,
	output logic signed [W+1:0]        lower_s1,
	output logic signed [W+1:0]        upper_s1,
	output logic        [W-1:0]        den_s1,
	output sbi_pkg::slab_flags_t       flags_s1
);

	logic signed [W:0]   delta;
	logic signed [W:0]   delta_neg;
	logic signed [W:0]   high;
	logic signed [W+1:0] s2, lo2, hi2;
	logic                neg;
	sbi_pkg::slab_flags_t flags;

	assign delta     = {stop[W-1], stop} - {start[W-1], start};
	assign delta_neg = -delta;
	assign high      = {low[W-1], low} + $signed({2'b00, extent});
	assign neg       = delta[W];

	assign s2  = {{2{start[W-1]}}, start};
	assign lo2 = {{2{low[W-1]}}, low};
	assign hi2 = {high[W], high};

	assign flags.par    = (delta == '0);
	assign flags.par_ok = (s2 >= lo2) && (s2 <= hi2);

	always_ff @(posedge clk) begin
		if (en) begin
			lower_s1 <= neg ? (s2 - hi2) : (lo2 - s2);
			upper_s1 <= neg ? (s2 - lo2) : (hi2 - s2);
			// |delta| < 2^W, so W bits hold the denominator
			den_s1   <= neg ? delta_neg[W-1:0] : delta[W-1:0];
			flags_s1 <= flags;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/sbi_merge.sv
// Merge stage: cross-multiplied slab comparisons across the three lanes.
`default_nettype none
module sbi_merge #(
	parameter int unsigned W = 32
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic signed [W+1:0]  lower [sbi_pkg::NUM_AXES],
	input  wire logic signed [W+1:0]  upper [sbi_pkg::NUM_AXES],
	input  wire logic        [W-1:0]  den   [sbi_pkg::NUM_AXES],
	input  wire sbi_pkg::slab_flags_t flags [sbi_pkg::NUM_AXES],
	output logic                      hit
);

	logic signed [2*W+2:0] lhs_s2  [sbi_pkg::NUM_PAIRS];
	logic signed [2*W+2:0] rhs_s2  [sbi_pkg::NUM_PAIRS];
	logic                  need_s2 [sbi_pkg::NUM_PAIRS];
	logic                  ok_s2   [sbi_pkg::NUM_AXES];
	logic [sbi_pkg::NUM_PAIRS-1:0] pair_ok;
	logic [sbi_pkg::NUM_AXES-1:0]  axis_ok;

	// lower_i / den_i <= upper_j / den_j  <=>  lower_i * den_j <= upper_j * den_i
	for (genvar p = 0; p < sbi_pkg::NUM_PAIRS; p++) begin : g_pair
		always_ff @(posedge clk) begin
			if (en) begin
				lhs_s2[p]  <= lower[sbi_pkg::PAIR_I[p]] *
					$signed({1'b0, den[sbi_pkg::PAIR_J[p]]});
				rhs_s2[p]  <= upper[sbi_pkg::PAIR_J[p]] *
					$signed({1'b0, den[sbi_pkg::PAIR_I[p]]});
				need_s2[p] <= !flags[sbi_pkg::PAIR_I[p]].par &&
					!flags[sbi_pkg::PAIR_J[p]].par;
			end
		end
		assign pair_ok[p] = !need_s2[p] || (lhs_s2[p] <= rhs_s2[p]);
	end

	// Single-axis check: parallel test, or slab overlaps t in [0,1]
	for (genvar a = 0; a < sbi_pkg::NUM_AXES; a++) begin : g_axis
		always_ff @(posedge clk) begin
			if (en) begin
				ok_s2[a] <= flags[a].par ? flags[a].par_ok :
					((lower[a] <= $signed({2'b00, den[a]})) && !upper[a][W+1]);
			end
		end
		assign axis_ok[a] = ok_s2[a];
	end

	assign hit = (&axis_ok) && (&pair_ok);

endmodule
`default_nettype wire

FILE: hdl/segment_box_intersect.sv
// Top level of the exact segment versus axis-aligned box intersection test.
// Each request word carries a 3-D segment (start, end) and a box (low corner,
// non-negative extents) in signed fixed point; the response word is hit = 1
// when some t in [0,1] puts the segment inside the closed box on all axes.
// Three axis lanes work side by side and a merge stage combines them by
// exact cross-multiplication, so there is no rounding anywhere. The block
// takes one word per cycle while req_stall is low, and answers through the lane
// subtract register, then the cross-product multiply register, then the compare
// into the response register. The whole pipeline holds while a response word is
// stalled, so req_stall follows rsp_valid && rsp_stall.
`default_nettype none
module segment_box_intersect #(
	parameter int unsigned COORD_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// request channel
	input  wire logic                          req_valid,
	output logic                               req_stall,
	input  wire logic signed [COORD_WIDTH-1:0] seg_start_x,
	input  wire logic signed [COORD_WIDTH-1:0] seg_start_y,
	input  wire logic signed [COORD_WIDTH-1:0] seg_start_z,
	input  wire logic signed [COORD_WIDTH-1:0] seg_end_x,
	input  wire logic signed [COORD_WIDTH-1:0] seg_end_y,
	input  wire logic signed [COORD_WIDTH-1:0] seg_end_z,
	input  wire logic signed [COORD_WIDTH-1:0] box_low_x,
	input  wire logic signed [COORD_WIDTH-1:0] box_low_y,
	input  wire logic signed [COORD_WIDTH-1:0] box_low_z,
	input  wire logic        [COORD_WIDTH-2:0] box_extent_x,
	input  wire logic        [COORD_WIDTH-2:0] box_extent_y,
	input  wire logic        [COORD_WIDTH-2:0] box_extent_z,
	// response channel
	output logic                               rsp_valid,
	input  wire logic                          rsp_stall,
	output logic                               hit
);

	localparam int unsigned W = COORD_WIDTH;

	// Gather per-axis inputs so each lane sees one axis.
	logic signed [W-1:0] start  [sbi_pkg::NUM_AXES];
	logic signed [W-1:0] stop   [sbi_pkg::NUM_AXES];
	logic signed [W-1:0] low    [sbi_pkg::NUM_AXES];
	logic        [W-2:0] extent [sbi_pkg::NUM_AXES];

	assign start[0]  = seg_start_x;
	assign start[1]  = seg_start_y;
	assign start[2]  = seg_start_z;
	assign stop[0]   = seg_end_x;
	assign stop[1]   = seg_end_y;
	assign stop[2]   = seg_end_z;
	assign low[0]    = box_low_x;
	assign low[1]    = box_low_y;
	assign low[2]    = box_low_z;
	assign extent[0] = box_extent_x;
	assign extent[1] = box_extent_y;
	assign extent[2] = box_extent_z;

	// Lane outputs (stage 1)
	logic signed [W+1:0]  lower_s1 [sbi_pkg::NUM_AXES];
	logic signed [W+1:0]  upper_s1 [sbi_pkg::NUM_AXES];
	logic        [W-1:0]  den_s1   [sbi_pkg::NUM_AXES];
	sbi_pkg::slab_flags_t flags_s1 [sbi_pkg::NUM_AXES];

	logic en;         // pipeline advances
	logic v_s1, v_s2; // word present in stage 1 / stage 2
	logic rsp_valid_q;
	logic hit_q;
	logic merge_hit;

	// Everything moves unless the response register is full and held.
	assign en        = !(rsp_valid_q && rsp_stall);
	assign req_stall = !en;

	for (genvar a = 0; a < sbi_pkg::NUM_AXES; a++) begin : g_lane
		sbi_lane #(.W(W)) u_lane (
			.clk      (clk),
			.en       (en),
			.start    (start[a]),
			.stop     (stop[a]),
			.low      (low[a]),
			.extent   (extent[a]),
			.lower_s1 (lower_s1[a]),
			.upper_s1 (upper_s1[a]),
			.den_s1   (den_s1[a]),
			.flags_s1 (flags_s1[a])
		);
	end

	sbi_merge #(.W(W)) u_merge (
		.clk   (clk),
		.en    (en),
		.lower (lower_s1),
		.upper (upper_s1),
		.den   (den_s1),
		.flags (flags_s1),
		.hit   (merge_hit)
	);

	// Valid tracking along the pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= req_valid;
			v_s2        <= v_s1;
			rsp_valid_q <= v_s2;
		end
	end

	// Response payload register
	always_ff @(posedge clk) begin
		if (en) begin
			hit_q <= merge_hit;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign hit       = hit_q;

endmodule
`default_nettype wire

FILE: hdl/sbi_chk.sv
// Port-level checker for segment_box_intersect, bound to the top level.
`default_nettype none
`include "segment_box_intersect_defines.svh"
module sbi_chk #(
	parameter int unsigned COORD_WIDTH = 32
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          req_valid,
	input wire logic                          req_stall,
	input wire logic signed [COORD_WIDTH-1:0] seg_start_x,
	input wire logic signed [COORD_WIDTH-1:0] seg_start_y,
	input wire logic signed [COORD_WIDTH-1:0] seg_start_z,
	input wire logic signed [COORD_WIDTH-1:0] seg_end_x,
	input wire logic signed [COORD_WIDTH-1:0] seg_end_y,
	input wire logic signed [COORD_WIDTH-1:0] seg_end_z,
	input wire logic signed [COORD_WIDTH-1:0] box_low_x,
	input wire logic signed [COORD_WIDTH-1:0] box_low_y,
	input wire logic signed [COORD_WIDTH-1:0] box_low_z,
	input wire logic        [COORD_WIDTH-2:0] box_extent_x,
	input wire logic        [COORD_WIDTH-2:0] box_extent_y,
	input wire logic        [COORD_WIDTH-2:0] box_extent_z,
	input wire logic                          rsp_valid,
	input wire logic                          rsp_stall,
	input wire logic                          hit
);

	logic acc;
	logic pt_corner; // degenerate segment sitting on the box low corner
	logic miss_x;    // segment with constant x, off a zero-width box on x

	assign acc       = req_valid && !req_stall;
	assign pt_corner = (seg_start_x == seg_end_x) && (seg_start_y == seg_end_y) &&
		(seg_start_z == seg_end_z) && (seg_start_x == box_low_x) &&
		(seg_start_y == box_low_y) && (seg_start_z == box_low_z);
	assign miss_x    = (seg_start_x == seg_end_x) && (box_extent_x == '0) &&
		(seg_start_x != box_low_x);

	`SBI_ASSERT_NXT(a_latency, (acc ##1 !rsp_stall ##1 !rsp_stall), rsp_valid, "word lost in pipe")
	`SBI_ASSERT_NXT(a_corner_hit, ((acc && pt_corner) ##1 !rsp_stall ##1 !rsp_stall), (rsp_valid && hit), "corner point missed")
	`SBI_ASSERT_NXT(a_flat_miss, ((acc && miss_x) ##1 !rsp_stall ##1 !rsp_stall), (rsp_valid && !hit), "flat box false hit")
	`SBI_ASSERT_NXT(a_rsp_hold, (rsp_valid && rsp_stall), (rsp_valid && $stable(hit)), "stalled response changed")

endmodule

bind segment_box_intersect sbi_chk #(.COORD_WIDTH(COORD_WIDTH)) u_sbi_chk (.*);
`default_nettype wire

FILE: tb/segment_box_intersect_checker.sv
// Checker for segment_box_intersect: predicts each hit flag and compares responses in order.
module segment_box_intersect_checker #(
	parameter int CW = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic                 req_stall,
	input  logic signed [CW-1:0] seg_start_x,
	input  logic signed [CW-1:0] seg_start_y,
	input  logic signed [CW-1:0] seg_start_z,
	input  logic signed [CW-1:0] seg_end_x,
	input  logic signed [CW-1:0] seg_end_y,
	input  logic signed [CW-1:0] seg_end_z,
	input  logic signed [CW-1:0] box_low_x,
	input  logic signed [CW-1:0] box_low_y,
	input  logic signed [CW-1:0] box_low_z,
	input  logic        [CW-2:0] box_extent_x,
	input  logic        [CW-2:0] box_extent_y,
	input  logic        [CW-2:0] box_extent_z,
	input  logic                 rsp_valid,
	input  logic                 rsp_stall,
	input  logic                 hit,
	output int                   fail_count,
	output int                   pending,
	output int                   hits_seen,
	output int                   misses_seen
);

	localparam int DUE_DEPTH = 4096;

	// expected hit flags, oldest at due_rd
	logic hit_due [DUE_DEPTH];
	int   due_wr, due_rd;
	int   rsp_index;

	// Slab test with every bound kept as an exact fraction num/den, den > 0.
	function automatic logic slab_hit(input logic [2:0][CW-1:0] p0, input logic [2:0][CW-1:0] p1,
			input logic [2:0][CW-1:0] lo, input logic [2:0][CW-2:0] ext);
		logic signed [127:0] s, e, bl, bh, d, lnum, unum, den;
		logic signed [127:0] tmin_n, tmin_d, tmax_n, tmax_d;
		logic overlap;
		overlap = 1'b1;
		tmin_n = 0;
		tmin_d = 1;
		tmax_n = 1;
		tmax_d = 1;
		for (int a = 0; a < 3; a++) begin
			s  = $signed(p0[a]);
			e  = $signed(p1[a]);
			bl = $signed(lo[a]);
			bh = bl + ext[a];
			d  = e - s;
			if (d == 0) begin
				if (s < bl || s > bh)
					overlap = 1'b0;
			end else begin
				if (d > 0) begin
					lnum = bl - s;
					unum = bh - s;
					den  = d;
				end else begin
					lnum = s - bh;
					unum = s - bl;
					den  = -d;
				end
				if (lnum * tmin_d > tmin_n * den) begin
					tmin_n = lnum;
					tmin_d = den;
				end
				if (unum * tmax_d < tmax_n * den) begin
					tmax_n = unum;
					tmax_d = den;
				end
			end
		end
		if (tmin_n * tmax_d > tmax_n * tmin_d)
			overlap = 1'b0;
		return overlap;
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("MISMATCH: %s", msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic want;
		if (!arst_n) begin
			due_wr      = 0;
			due_rd      = 0;
			fail_count  = 0;
			pending     = 0;
			hits_seen   = 0;
			misses_seen = 0;
			rsp_index   = 0;
		end else begin
			// response first: a word accepted at this edge cannot be answered at the same edge
			if (rsp_valid && !rsp_stall) begin
				if (due_wr == due_rd) begin
					note_failure($sformatf("response %0d (hit=%b) with no word outstanding",
						rsp_index, hit));
				end else begin
					want = hit_due[due_rd % DUE_DEPTH];
					due_rd++;
					if (hit !== want)
						note_failure($sformatf("response %0d: hit expected %b, got %b",
							rsp_index, want, hit));
					else if (want)
						hits_seen++;
					else
						misses_seen++;
				end
				rsp_index++;
			end
			if (req_valid && !req_stall) begin
				hit_due[due_wr % DUE_DEPTH] = slab_hit({seg_start_z, seg_start_y, seg_start_x},
					{seg_end_z, seg_end_y, seg_end_x}, {box_low_z, box_low_y, box_low_x},
					{box_extent_z, box_extent_y, box_extent_x});
				due_wr++;
			end
			pending = due_wr - due_rd;
		end
	end

endmodule

FILE: tb/segment_box_intersect_tb.sv
// Testbench top for segment_box_intersect: stimulus, receiver stalls and the verdict.
module segment_box_intersect_tb;

	localparam int          CW           = 32;
	localparam int          PERIOD       = 4;
	localparam int          RESET_CYCLES = 12;
	localparam int          RANDOM_WORDS = 1230;
	localparam int          SQUEEZE_WORDS = 30;
	localparam int          HOLD_CYCLES  = 80;
	localparam int          DRAIN_LIMIT  = 5000;
	localparam int          RUN_LIMIT    = 2000000;   // time units, far above a slow correct run
	localparam int          C_MIN        = int'(32'h8000_0000);
	localparam int          C_MAX        = 32'h7FFF_FFFF;
	localparam int unsigned EXT_MAX      = 32'h7FFF_FFFF;

	// receiver stall patterns
	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_COMB
	} stall_mode_t;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 req_valid    = 1'b0;
	logic                 req_stall;
	logic signed [CW-1:0] seg_start_x  = '0;
	logic signed [CW-1:0] seg_start_y  = '0;
	logic signed [CW-1:0] seg_start_z  = '0;
	logic signed [CW-1:0] seg_end_x    = '0;
	logic signed [CW-1:0] seg_end_y    = '0;
	logic signed [CW-1:0] seg_end_z    = '0;
	logic signed [CW-1:0] box_low_x    = '0;
	logic signed [CW-1:0] box_low_y    = '0;
	logic signed [CW-1:0] box_low_z    = '0;
	logic        [CW-2:0] box_extent_x = '0;
	logic        [CW-2:0] box_extent_y = '0;
	logic        [CW-2:0] box_extent_z = '0;
	logic                 rsp_valid;
	logic                 rsp_stall    = 1'b0;
	logic                 hit;

	int   fail_count, pending, hits_seen, misses_seen;
	int   words_sent = 0;
	logic squeeze_req = 1'b0;   // asks the receiver for its long hold-off

	always #(PERIOD / 2) clk = ~clk;

	segment_box_intersect #(
		.COORD_WIDTH(CW)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.seg_start_x (seg_start_x),
		.seg_start_y (seg_start_y),
		.seg_start_z (seg_start_z),
		.seg_end_x   (seg_end_x),
		.seg_end_y   (seg_end_y),
		.seg_end_z   (seg_end_z),
		.box_low_x   (box_low_x),
		.box_low_y   (box_low_y),
		.box_low_z   (box_low_z),
		.box_extent_x(box_extent_x),
		.box_extent_y(box_extent_y),
		.box_extent_z(box_extent_z),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.hit         (hit)
	);

	segment_box_intersect_checker #(
		.CW(CW)
	) checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.seg_start_x (seg_start_x),
		.seg_start_y (seg_start_y),
		.seg_start_z (seg_start_z),
		.seg_end_x   (seg_end_x),
		.seg_end_y   (seg_end_y),
		.seg_end_z   (seg_end_z),
		.box_low_x   (box_low_x),
		.box_low_y   (box_low_y),
		.box_low_z   (box_low_z),
		.box_extent_x(box_extent_x),
		.box_extent_y(box_extent_y),
		.box_extent_z(box_extent_z),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.hit         (hit),
		.fail_count  (fail_count),
		.pending     (pending),
		.hits_seen   (hits_seen),
		.misses_seen (misses_seen)
	);

	// Offer one word from the falling edge and hold it until a rising edge
	// takes it (valid high, stall low). Returns at the next falling edge with
	// valid still high, so back-to-back words never drop valid.
	task automatic send_word(input int sx, input int sy, input int sz,
			input int ex, input int ey, input int ez,
			input int lx, input int ly, input int lz,
			input int unsigned wx, input int unsigned wy, input int unsigned wz);
		seg_start_x  = sx;
		seg_start_y  = sy;
		seg_start_z  = sz;
		seg_end_x    = ex;
		seg_end_y    = ey;
		seg_end_z    = ez;
		box_low_x    = lx;
		box_low_y    = ly;
		box_low_z    = lz;
		box_extent_x = wx[CW-2:0];
		box_extent_y = wy[CW-2:0];
		box_extent_z = wz[CW-2:0];
		req_valid    = 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic idle(input int cycles);
		req_valid = 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// Symmetric offset in [-r, r].
	function automatic int spread(input int r);
		return int'($urandom_range(0, 2 * r)) - r;
	endfunction

	// Corner values of a signed coordinate, or a raw random one.
	function automatic int pick_edge();
		case ($urandom_range(0, 9))
			0:       return C_MIN;
			1:       return C_MIN + 1;
			2:       return -1;
			3:       return 0;
			4:       return 1;
			5:       return C_MAX - 1;
			6:       return C_MAX;
			default: return $urandom;
		endcase
	endfunction

	function automatic int unsigned pick_extent_edge();
		case ($urandom_range(0, 5))
			0:       return 0;
			1:       return 1;
			2:       return EXT_MAX - 1;
			3:       return EXT_MAX;
			default: return $urandom & EXT_MAX;
		endcase
	endfunction

	// One random word. Most are built around the box so hits, misses and
	// exact touches all turn up; the rest are raw bit patterns and corner values.
	task automatic send_random();
		int          s[3], e[3], l[3];
		int unsigned w[3];
		int          kind, r, base;
		kind = $urandom_range(0, 99);
		r = ($urandom_range(0, 2) == 0) ? 8 : ($urandom_range(0, 1) ? 1000 : (1 << 20));
		for (int a = 0; a < 3; a++) begin
			if (kind < 10) begin
				// raw noise: every bit of every field toggles
				s[a] = $urandom;
				e[a] = $urandom;
				l[a] = $urandom;
				w[a] = $urandom & EXT_MAX;
			end else if (kind < 25) begin
				s[a] = pick_edge();
				e[a] = pick_edge();
				l[a] = pick_edge();
				w[a] = pick_extent_edge();
			end else begin
				// small-scale scene at a random offset; stays clear of overflow
				base = int'($urandom_range(0, 32'h7FFF_FFFF)) - 32'h4000_0000;
				l[a] = base + spread(r);
				w[a] = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, r);
				s[a] = l[a] - r + int'($urandom_range(0, w[a] + 2 * r));
				e[a] = l[a] - r + int'($urandom_range(0, w[a] + 2 * r));
				if (kind < 45)
					s[a] = l[a] + int'($urandom_range(0, w[a]));   // starts in the box: sure hit
				else if ($urandom_range(0, 4) == 0)
					s[a] = $urandom_range(0, 1) ? l[a] : l[a] + int'(w[a]);   // on a face
				if ($urandom_range(0, 4) == 0)
					e[a] = $urandom_range(0, 1) ? l[a] : l[a] + int'(w[a]);
				if ($urandom_range(0, 6) == 0)
					e[a] = s[a];   // parallel to this axis
			end
		end
		send_word(s[0], s[1], s[2], e[0], e[1], e[2], l[0], l[1], l[2], w[0], w[1], w[2]);
	endtask

	// Receiver: stalls per random pattern segment, with one long hold-off
	// when the sender asks for it so the pipeline fills and req_stall rises.
	initial begin
		stall_mode_t mode;
		int          seg_left, hold_left, phase;
		bit          squeeze_done;
		mode         = STALL_NONE;
		seg_left     = 0;
		hold_left    = 0;
		phase        = 0;
		squeeze_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				rsp_stall = 1'b1;
				hold_left--;
			end else if (squeeze_req && !squeeze_done) begin
				rsp_stall    = 1'b1;
				hold_left    = HOLD_CYCLES - 1;
				squeeze_done = 1'b1;
			end else begin
				if (seg_left == 0) begin
					mode     = stall_mode_t'($urandom_range(0, 3));
					seg_left = $urandom_range(10, 150);
				end
				seg_left--;
				phase++;
				case (mode)
					STALL_NONE:  rsp_stall = 1'b0;
					STALL_LIGHT: rsp_stall = ($urandom_range(0, 3) == 0);
					STALL_HEAVY: rsp_stall = ($urandom_range(0, 3) != 0);
					default:     rsp_stall = (phase % 5) < 2;
				endcase
			end
		end
	end

	// Hard stop in case the block hangs.
	initial begin
		#(RUN_LIMIT);
		$display("Timeout after %0d time units, %0d words outstanding", RUN_LIMIT, pending);
		$display("Verification failed");
		$finish;
	end

	initial begin
		int sent, burst, gap, waited;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed words: origin point, crossing, parallel axes at and past
		// each face, touching only at t = 0 or t = 1, edge graze, point-in-box,
		// flat box, and the coordinate and extent extremes.
		send_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_word(-10, -10, -10, 10, 10, 10, -1, -1, -1, 2, 2, 2);
		send_word(-10, 5, 0, 10, 5, 0, 0, 0, 0, 2, 2, 2);
		send_word(-10, 2, 0, 10, 2, 0, 0, 0, 0, 2, 2, 2);
		idle(2);
		send_word(-10, 3, 0, 10, 3, 0, 0, 0, 0, 2, 2, 2);
		send_word(-10, 0, 1, 10, 0, 1, 0, 0, 0, 2, 2, 2);
		send_word(-10, -1, 1, 10, -1, 1, 0, 0, 0, 2, 2, 2);
		send_word(-10, 1, 1, 0, 1, 1, 0, 0, 0, 2, 2, 2);
		idle(1);
		send_word(-10, 1, 1, -1, 1, 1, 0, 0, 0, 2, 2, 2);
		send_word(2, 1, 1, 10, 1, 1, 0, 0, 0, 2, 2, 2);
		send_word(-1, 1, 1, 1, -1, 1, 0, 0, 0, 2, 2, 2);
		send_word(-2, 1, 1, 1, -2, 1, 0, 0, 0, 2, 2, 2);
		send_word(1, 1, 1, 1, 1, 1, 0, 0, 0, 2, 2, 2);
		idle(3);
		send_word(3, 1, 1, 3, 1, 1, 0, 0, 0, 2, 2, 2);
		send_word(1, 1, -5, 1, 1, 5, 0, 0, 0, 2, 2, 0);
		send_word(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
			EXT_MAX, EXT_MAX, EXT_MAX);
		send_word(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 0, 0, 0);
		send_word(C_MAX, C_MAX, C_MAX, 0, 0, 0, C_MIN, C_MIN, C_MIN,
			EXT_MAX, EXT_MAX, EXT_MAX);
		send_word(C_MAX, C_MAX, C_MAX, -1, -1, -1, C_MIN, C_MIN, C_MIN,
			EXT_MAX, EXT_MAX, EXT_MAX);
		send_word(-1, -1, -1, -1, -1, -1, -1, -1, -1, EXT_MAX, EXT_MAX, EXT_MAX);
		send_word(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, -1, 0, 1, 0, 0, 0);
		send_word(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 0, 0, 0, 0, 0, 0);
		idle(4);

		// Long receiver hold-off while words keep coming back to back.
		squeeze_req = 1'b1;
		for (int i = 0; i < SQUEEZE_WORDS; i++)
			send_random();

		// Random words in bursts with random gaps between them.
		sent = SQUEEZE_WORDS;
		while (sent < RANDOM_WORDS) begin
			burst = $urandom_range(1, 40);
			for (int i = 0; i < burst && sent < RANDOM_WORDS; i++) begin
				send_random();
				sent++;
			end
			case ($urandom_range(0, 3))
				0:       gap = 0;
				1:       gap = $urandom_range(4, 12);
				default: gap = $urandom_range(1, 3);
			endcase
			if (gap > 0)
				idle(gap);
		end
		req_valid = 1'b0;

		// Drain, then keep the clock running to catch a stray response.
		waited = 0;
		while (pending != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (10) @(negedge clk);

		$display("Ran %0d segment/box words (%0d hits, %0d misses), with corner cases,",
			words_sent, hits_seen, misses_seen);
		$display("random stall patterns and one %0d-cycle receiver hold-off.", HOLD_CYCLES);
		if (pending != 0)
			$display("%0d words never answered", pending);
		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
